[design/bsc_pkg.sv]
// Shared types and constants for the byte signature counter.
// No dependencies; imported by bsc_window and byte_signature_counter_top.
`timescale 1ns / 1ps

package bsc_pkg;

    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int LEN_W      = 6;
    localparam int WORD_W     = 64;
    localparam int PAT_WORDS  = 4;
    localparam int WORD_BYTES = WORD_W / BYTE_W;
    localparam int PAT_BYTES  = PAT_WORDS * WORD_BYTES;
    localparam int PAT_IDX_W  = $clog2(PAT_BYTES);
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH   = 3'd0,
        CFG_PATTERN_WORD0    = 3'd1,
        CFG_PATTERN_WORD1    = 3'd2,
        CFG_PATTERN_WORD2    = 3'd3,
        CFG_PATTERN_WORD3    = 3'd4,
        CFG_EXPECTED_ADDRESS = 3'd5
    } cfg_reg_t;

    typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern_bytes_t;

    typedef struct packed {
        logic go;
        logic new_section;
        logic executable;
        logic last;
    } bsc_step_t;

endpackage

[design/bsc_window.sv]
// Byte window, section fill count and parallel pattern compare.
// Depends on bsc_pkg.
`timescale 1ns / 1ps

module bsc_window
    import bsc_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int CNT_W       = $clog2(MAX_PATTERN + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pattern_bytes_t        pattern_bytes,
    input  logic [CNT_W-1:0]      eff_len,
    input  bsc_step_t             step,
    input  logic [BYTE_W-1:0]     data_byte,
    output logic                  hit
);

    logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_reg;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_next;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] aligned_reg;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] aligned_next;
    logic [MAX_PATTERN-1:0]             mask_reg;
    logic [MAX_PATTERN-1:0]             mask_next;
    logic [MAX_PATTERN-1:0]             byte_eq;
    logic [CNT_W-1:0]                   fill_reg;
    logic [CNT_W-1:0]                   fill_next;
    logic [CNT_W-1:0]                   fill_base;
    logic [CNT_W-1:0]                   fill_inc;

    // Align the pattern to window order: window slot j holds pattern byte n-1-j.
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            mask_next[j]    = CNT_W'(j) < eff_len;
            aligned_next[j] = pattern_bytes[PAT_IDX_W'(int'(eff_len) - 1 - j)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        aligned_reg <= aligned_next;
    end

    always_comb
    begin
        win_next[0] = data_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            win_next[k] = win_reg[k-1];
        end
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            byte_eq[j] = (win_next[j] == aligned_reg[j]) || !mask_reg[j];
        end
    end

    assign fill_base = step.new_section ? '0 : fill_reg;
    assign fill_inc  = (fill_base < CNT_W'(MAX_PATTERN)) ? fill_base + 1'b1 : fill_base;
    assign hit       = step.executable && (fill_inc >= eff_len) && (&byte_eq);

    always_comb
    begin
        if (step.last)
        begin
            fill_next = '0;
        end
        else if (step.executable)
        begin
            fill_next = fill_inc;
        end
        else
        begin
            fill_next = fill_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (step.go)
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.go && step.executable)
        begin
            win_reg <= win_next;
        end
    end

endmodule

[design/byte_signature_counter_top.sv]
// Top level of the byte signature counter: configuration registers,
// input stage, match counting and result register. Depends on bsc_pkg, bsc_window.
`timescale 1ns / 1ps

// Scans a stream of section bytes for a configured pattern of 1 to MAX_PATTERN
// bytes and reports, on the transaction flagged last_byte, the saturating match
// count, the start address of the first match and whether exactly one match
// sits at expected_address. One byte is taken every cycle unless a last byte
// waits in the input stage for the result register to free. A byte is registered
// on entry and compared against the whole window from the input stage, and the
// result is held in the result register. Configuration writes are always accepted
// (cfg_ready is always high) and are picked up by the next byte taken after the write.
module byte_signature_counter_top
    import bsc_pkg::*;
#(
    parameter int MAX_PATTERN = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic [ADDR_W-1:0]    byte_address,
    input  logic                 new_section,
    input  logic                 section_executable,
    input  logic                 last_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [COUNT_W-1:0]   match_count,
    output logic [ADDR_W-1:0]    first_match_address,
    output logic                 unique_at_expected
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    logic [LEN_W-1:0]                  len_reg;
    logic [PAT_WORDS-1:0][WORD_W-1:0]  word_reg;
    logic [ADDR_W-1:0]                 expected_reg;
    pattern_bytes_t                    pattern_bytes;
    logic [CNT_W-1:0]                  eff_len;

    logic                s1_valid_reg;
    logic [BYTE_W-1:0]   s1_data_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic                s1_start_reg;
    logic                s1_exec_reg;
    logic                s1_last_reg;

    logic                out_free;
    logic                go;
    bsc_step_t           step;
    logic                hit;

    logic [COUNT_W-1:0]  found_reg;
    logic [COUNT_W-1:0]  found_next;
    logic [ADDR_W-1:0]   first_reg;
    logic [ADDR_W-1:0]   first_next;
    logic [ADDR_W-1:0]   start_addr;

    logic                out_valid_reg;
    logic [COUNT_W-1:0]  count_out_reg;
    logic [ADDR_W-1:0]   addr_out_reg;
    logic                unique_out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= LEN_W'(1);
            word_reg     <= '0;
            expected_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LENGTH:   len_reg      <= cfg_data[LEN_W-1:0];
                CFG_PATTERN_WORD0:    word_reg[0]  <= cfg_data;
                CFG_PATTERN_WORD1:    word_reg[1]  <= cfg_data;
                CFG_PATTERN_WORD2:    word_reg[2]  <= cfg_data;
                CFG_PATTERN_WORD3:    word_reg[3]  <= cfg_data;
                CFG_EXPECTED_ADDRESS: expected_reg <= cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < PAT_BYTES; i++)
        begin
            pattern_bytes[i] = word_reg[i / WORD_BYTES][(i % WORD_BYTES) * BYTE_W +: BYTE_W];
        end
    end

    // Clamp the length into 1..MAX_PATTERN.
    always_comb
    begin
        priority if (len_reg == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (len_reg > LEN_W'(MAX_PATTERN))
        begin
            eff_len = CNT_W'(MAX_PATTERN);
        end
        else
        begin
            eff_len = CNT_W'(len_reg);
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign go       = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready = !s1_valid_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg  <= data_byte;
            s1_addr_reg  <= byte_address;
            s1_start_reg <= new_section;
            s1_exec_reg  <= section_executable;
            s1_last_reg  <= last_byte;
        end
    end

    assign step.go          = go;
    assign step.new_section = s1_start_reg;
    assign step.executable  = s1_exec_reg;
    assign step.last        = s1_last_reg;

    bsc_window #(
        .MAX_PATTERN (MAX_PATTERN),
        .CNT_W       (CNT_W)
    ) u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .pattern_bytes (pattern_bytes),
        .eff_len       (eff_len),
        .step          (step),
        .data_byte     (s1_data_reg),
        .hit           (hit)
    );

    assign start_addr = s1_addr_reg - ADDR_W'(eff_len - 1'b1);

    always_comb
    begin
        found_next = found_reg;
        first_next = first_reg;
        if (hit)
        begin
            if (found_reg == '0)
            begin
                first_next = start_addr;
            end
            if (found_reg != '1)
            begin
                found_next = found_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= '0;
            first_reg <= '0;
        end
        else if (go)
        begin
            if (s1_last_reg)
            begin
                found_reg <= '0;
                first_reg <= '0;
            end
            else
            begin
                found_reg <= found_next;
                first_reg <= first_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && s1_last_reg)
        begin
            count_out_reg  <= found_next;
            addr_out_reg   <= first_next;
            unique_out_reg <= (found_next == COUNT_W'(1)) && (first_next == expected_reg);
        end
    end

    assign out_valid           = out_valid_reg;
    assign match_count         = count_out_reg;
    assign first_match_address = addr_out_reg;
    assign unique_at_expected  = unique_out_reg;

endmodule

[sim/tb_byte_signature_counter_top.sv]
// Self-checking testbench for byte_signature_counter_top: directed table and random scans,
// checked against hand-written row expectations or an in-bench pattern search predictor.
// Depends on bsc_pkg and the byte_signature_counter_top RTL only.
`timescale 1ns / 1ps

module tb_byte_signature_counter_top
    import bsc_pkg::*;
;

    localparam int MAX_PATTERN  = 32;
    localparam int RANDOM_ITEMS = 1370;
    localparam int PHASE_ITEMS  = 100;
    localparam int DIR_ROWS     = 22;

    typedef struct packed {
        logic [COUNT_W-1:0] hits;
        logic [ADDR_W-1:0]  first_addr;
        logic               at_expected;
    } scan_result_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w3;
        logic [ADDR_W-1:0] exp_addr;
    } pattern_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic [ADDR_W-1:0] a;
        logic              ns;
        logic              ex;
        logic              lb;
        logic              typed;
        logic [1:0]        cfg_sel;
        scan_result_t      want;
    } dir_row_t;

    localparam pattern_cfg_t DIRECTED_CFG [0:1] = '{
        '{6'd0, 64'h0000_0000_0000_00A5, 64'h0, 64'h0, 64'h0, 32'h0000_1000},
        '{6'd3, 64'h0000_0000_0033_2211, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, 32'hFFFF_FFFF}
    };

    localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
        '{8'h00, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 2'd0, '{16'd1, 32'h0000_0000, 1'b1}},
        '{8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 2'd0, '{16'd0, 32'h0000_0000, 1'b0}},
        '{8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b1, 2'd0, '{16'd0, 32'h0000_0000, 1'b0}},
        '{8'hA5, 32'h0000_1000, 1'b1, 1'b1, 1'b0, 1'b0, 2'd1, '0},
        '{8'hA5, 32'h0000_1001, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, '0},
        '{8'h5A, 32'h0000_1002, 1'b0, 1'b1, 1'b1, 1'b1, 2'd0, '{16'd1, 32'h0000_1000, 1'b1}},
        '{8'h11, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 2'd2, '0},
        '{8'h22, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0, '0},
        '{8'h33, 32'h0000_0001, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0, '0},
        '{8'h11, 32'h0000_0002, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0, '0},
        '{8'h22, 32'h0000_0003, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0, '0},
        '{8'h33, 32'h0000_0004, 1'b0, 1'b1, 1'b1, 1'b1, 2'd0, '{16'd1, 32'hFFFF_FFFF, 1'b1}},
        '{8'h11, 32'h0000_0010, 1'b1, 1'b1, 1'b0, 1'b0, 2'd0, '0},
        '{8'h22, 32'h0000_0011, 1'b1, 1'b1, 1'b0, 1'b0, 2'd0, '0},
        '{8'h33, 32'h0000_0012, 1'b0, 1'b1, 1'b1, 1'b1, 2'd0, '{16'd0, 32'h0000_0000, 1'b0}},
        '{8'h11, 32'h0000_0020, 1'b1, 1'b1, 1'b0, 1'b0, 2'd0, '0},
        '{8'h22, 32'h0000_0021, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0, '0},
        '{8'h33, 32'h0000_0022, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0, '0},
        '{8'h11, 32'h0000_0023, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0, '0},
        '{8'h22, 32'h0000_0024, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0, '0},
        '{8'h33, 32'h0000_0025, 1'b0, 1'b1, 1'b1, 1'b1, 2'd0, '{16'd2, 32'h0000_0020, 1'b0}},
        '{8'hC3, 32'h8000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 2'd0, '0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PATTERN_LENGTH;
    logic [WORD_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    data_byte = '0;
    logic [ADDR_W-1:0]    byte_address = '0;
    logic                 new_section = 1'b0;
    logic                 section_executable = 1'b0;
    logic                 last_byte = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b1;
    logic [COUNT_W-1:0]   match_count;
    logic [ADDR_W-1:0]    first_match_address;
    logic                 unique_at_expected;

    // Directed rows that carry a hand-written expectation travel with the transaction
    logic                 row_typed = 1'b0;
    scan_result_t         row_want = '0;

    // Predictor state and register copies
    logic [BYTE_W-1:0]    recent [MAX_PATTERN] = '{default: '0};
    int unsigned          run_len = 0;
    logic [COUNT_W-1:0]   hit_total = '0;
    logic [ADDR_W-1:0]    first_hit = '0;
    logic [LEN_W-1:0]     pat_len = 6'd1;
    logic [WORD_W-1:0]    pat_word [PAT_WORDS] = '{default: '0};
    logic [ADDR_W-1:0]    exp_addr = '0;

    scan_result_t         pending_results [$];
    int                   error_count = 0;
    int                   results_seen = 0;
    int                   bytes_taken = 0;
    int                   reg_writes = 0;
    int                   scan_items = 0;
    int                   stall_left = 0;
    bit                   in_idle_on = 1'b0;
    bit                   out_stall_on = 1'b0;

    byte_signature_counter_top #(
        .MAX_PATTERN(MAX_PATTERN)
    ) i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .data_byte          (data_byte),
        .byte_address       (byte_address),
        .new_section        (new_section),
        .section_executable (section_executable),
        .last_byte          (last_byte),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .match_count        (match_count),
        .first_match_address(first_match_address),
        .unique_at_expected (unique_at_expected)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int eff_len();
        if (pat_len == 0)
            return 1;
        if (pat_len > MAX_PATTERN)
            return MAX_PATTERN;
        return int'(pat_len);
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_byte(input int i);
        return pat_word[i / WORD_BYTES][(i % WORD_BYTES) * BYTE_W +: BYTE_W];
    endfunction

    // Shift one executable byte into the window, count a full pattern match, emit on the last byte
    task automatic advance_scan(input logic [BYTE_W-1:0] b, input logic [ADDR_W-1:0] a,
                                input logic ns, input logic ex, input logic lb,
                                output bit has_result, output scan_result_t r);
        int n;
        int i;
        bit hit;
        has_result = 1'b0;
        r = '0;
        if (ns)
            run_len = 0;
        if (ex)
        begin
            n = eff_len();
            for (i = MAX_PATTERN - 1; i > 0; i--)
                recent[i] = recent[i-1];
            recent[0] = b;
            if (run_len < MAX_PATTERN)
                run_len++;
            hit = (run_len >= n);
            for (i = 0; i < n; i++)
                if (recent[n-1-i] != pattern_byte(i))
                    hit = 1'b0;
            if (hit)
            begin
                if (hit_total == 0)
                    first_hit = a - ADDR_W'(n - 1);
                if (hit_total != {COUNT_W{1'b1}})
                    hit_total++;
            end
        end
        if (lb)
        begin
            has_result = 1'b1;
            r.hits = hit_total;
            r.first_addr = first_hit;
            r.at_expected = (hit_total == 1) && (first_hit == exp_addr);
            hit_total = '0;
            first_hit = '0;
            run_len = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t ns", what, got, want, $time);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            reg_writes++;
            case (cfg_index)
                CFG_PATTERN_LENGTH:   pat_len = cfg_data[LEN_W-1:0];
                CFG_PATTERN_WORD0:    pat_word[0] = cfg_data;
                CFG_PATTERN_WORD1:    pat_word[1] = cfg_data;
                CFG_PATTERN_WORD2:    pat_word[2] = cfg_data;
                CFG_PATTERN_WORD3:    pat_word[3] = cfg_data;
                CFG_EXPECTED_ADDRESS: exp_addr = cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin : byte_monitor
        bit has_result;
        scan_result_t r;
        if (rst_n && in_valid && in_ready)
        begin
            bytes_taken++;
            advance_scan(data_byte, byte_address, new_section, section_executable, last_byte,
                         has_result, r);
            if (has_result)
                pending_results.insert(pending_results.size(), row_typed ? row_want : r);
        end
    end

    always @(posedge clk)
    begin : result_check
        scan_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, match_count", match_count, 0);
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                if (match_count !== want.hits)
                    report_mismatch("match_count", match_count, want.hits);
                if (first_match_address !== want.first_addr)
                    report_mismatch("first_match_address", first_match_address, want.first_addr);
                if (unique_at_expected !== want.at_expected)
                    report_mismatch("unique_at_expected", unique_at_expected, want.at_expected);
            end
        end
    end

    // Result-side back-pressure in bursts
    always @(posedge clk)
    begin : stall_gen
        int nxt;
        if (stall_left > 0)
            nxt = stall_left - 1;
        else if (out_stall_on && $urandom_range(0, 5) == 0)
            nxt = $urandom_range(1, 11);
        else
            nxt = 0;
        stall_left <= nxt;
        out_ready <= (nxt == 0);
    end

    task automatic drive_byte(input logic [BYTE_W-1:0] b, input logic [ADDR_W-1:0] a,
                              input logic ns, input logic ex, input logic lb,
                              input bit typed, input scan_result_t want);
        if (in_idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        byte_address <= a;
        new_section <= ns;
        section_executable <= ex;
        last_byte <= lb;
        row_typed <= typed;
        row_want <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        scan_items++;
    endtask

    // Hold the sender until every result is back, then let the pipeline settle
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_settings(input pattern_cfg_t s);
        write_reg(CFG_PATTERN_LENGTH, WORD_W'(s.len));
        write_reg(CFG_PATTERN_WORD0, s.w0);
        write_reg(CFG_PATTERN_WORD1, s.w1);
        write_reg(CFG_PATTERN_WORD2, s.w2);
        write_reg(CFG_PATTERN_WORD3, s.w3);
        write_reg(CFG_EXPECTED_ADDRESS, WORD_W'(s.exp_addr));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_base();
        case ($urandom_range(0, 3))
            0:       return 32'hFFFF_FFFF - $urandom_range(0, 40);
            1:       return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    // One scan: a few sections of pattern copies, near misses and random filler
    task automatic run_scan(input bit plant);
        int n;
        int nsec;
        int s;
        int k;
        int target;
        bit ex;
        logic [ADDR_W-1:0] base;
        logic [BYTE_W-1:0] sec_bytes [$];
        n = eff_len();
        nsec = $urandom_range(1, 3);
        for (s = 0; s < nsec; s++)
        begin
            sec_bytes.delete();
            target = $urandom_range(1, n + 6);
            if (plant && s == 0)
            begin
                ex = 1'b1;
                base = exp_addr;
                for (k = 0; k < n; k++)
                    sec_bytes.insert(sec_bytes.size(), pattern_byte(k));
            end
            else
            begin
                ex = ($urandom_range(0, 5) != 0);
                base = pick_base();
            end
            while (sec_bytes.size() < target)
            begin
                if (!plant && $urandom_range(0, 3) == 0)
                begin
                    for (k = 0; k < n; k++)
                        sec_bytes.insert(sec_bytes.size(), pattern_byte(k));
                end
                else if ($urandom_range(0, 1) == 1)
                    sec_bytes.insert(sec_bytes.size(),
                                     pattern_byte($urandom_range(0, n - 1)));
                else
                    sec_bytes.insert(sec_bytes.size(), BYTE_W'($urandom_range(0, 255)));
            end
            for (k = 0; k < sec_bytes.size(); k++)
                drive_byte(sec_bytes[k], base + k, k == 0, ex,
                           (s == nsec - 1) && (k == sec_bytes.size() - 1), 1'b0, '0);
        end
    endtask

    task automatic run_noise();
        int k;
        for (k = $urandom_range(1, 4); k > 0; k--)
            drive_byte(BYTE_W'($urandom_range(0, 255)), $urandom, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, 1'b0, '0);
    endtask

    initial
    begin : stimulus
        int r;
        int phase;
        int phase_start;
        pattern_cfg_t s;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        in_idle_on = 1'b1;
        out_stall_on = 1'b1;
        @(posedge clk);

        for (r = 0; r < DIR_ROWS; r++)
        begin
            if (DIRECTED[r].cfg_sel != 0)
            begin
                drain_pipeline();
                write_settings(DIRECTED_CFG[DIRECTED[r].cfg_sel - 1]);
            end
            drive_byte(DIRECTED[r].b, DIRECTED[r].a, DIRECTED[r].ns, DIRECTED[r].ex,
                       DIRECTED[r].lb, DIRECTED[r].typed, DIRECTED[r].want);
        end

        scan_items = 0;
        phase = 0;
        while (scan_items < RANDOM_ITEMS)
        begin
            drain_pipeline();
            case (phase)
                0:       s.len = 6'd32;
                1:       s.len = 6'd63;
                2:       s.len = 6'd0;
                3:       s.len = LEN_W'($urandom_range(33, 63));
                default: s.len = LEN_W'(($urandom_range(0, 4) == 0) ? $urandom_range(5, 32)
                                                                    : $urandom_range(1, 4));
            endcase
            s.w0 = {$urandom, $urandom};
            s.w1 = {$urandom, $urandom};
            s.w2 = {$urandom, $urandom};
            s.w3 = {$urandom, $urandom};
            if (phase == 1)
                {s.w0, s.w1, s.w2, s.w3} = '1;
            else if (phase == 2)
                {s.w0, s.w1, s.w2, s.w3} = '0;
            s.exp_addr = pick_base();
            write_settings(s);
            in_idle_on = (scan_items < 1150) && ($urandom_range(0, 3) != 0);
            out_stall_on = (scan_items < 1150) && ($urandom_range(0, 3) != 0);
            phase_start = scan_items;
            while (scan_items - phase_start < PHASE_ITEMS && scan_items < RANDOM_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                    run_noise();
                else
                    run_scan($urandom_range(0, 2) == 0);
            end
            phase++;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes and %0d register writes over %0d random settings;",
                 bytes_taken, reg_writes, phase);
        $display("%0d results checked, lengths 0, 1-4, 32 and above 32, wrap and section breaks.",
                 results_seen);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Timed out with %0d results outstanding", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
design/bsc_pkg.sv
design/bsc_window.sv
design/byte_signature_counter_top.sv
sim/tb_byte_signature_counter_top.sv
